### hdl/rta_pkg.sv
// Shared types and constants for the per-task runtime accounting block.
package rta_pkg;

   localparam int TS_W    = 32;
   localparam int ID_W    = 14;
   localparam int SLICE_W = 23;

   // x / 1000 == (x * DIV_MAGIC) >> DIV_SHIFT, exact for every 32-bit unsigned x
   localparam int          MAGIC_W   = 29;
   localparam logic [28:0] DIV_MAGIC = 29'h10624DD3;
   localparam int          DIV_SHIFT = 38;
   localparam int          PROD_W    = TS_W + MAGIC_W;

   typedef struct packed {
      logic clear;    // clear one table entry
      logic capture;  // take the request beat
      logic read;     // read both tables at the outgoing id
      logic mul;      // reciprocal multiply
      logic acc;      // accumulate, write back, form result
      logic push;     // move result into the output register
   } rta_cmd_type;

   typedef struct packed {
      logic clear_last;
      logic out_free;
   } rta_status_type;

endpackage

### hdl/rta_if.sv
// Channel interfaces: task switch requests and accounting responses.
interface rta_req_if;
   import rta_pkg::*;
   logic                     valid;
   logic                     ready;
   logic signed [TS_W-1:0]   switch_time_ns;
   logic        [ID_W-1:0]   outgoing_task;
   logic        [ID_W-1:0]   incoming_task;

   modport source (output valid, switch_time_ns, outgoing_task, incoming_task, input ready);
   modport sink   (input valid, switch_time_ns, outgoing_task, incoming_task, output ready);
endinterface

interface rta_rsp_if;
   import rta_pkg::*;
   logic                      valid;
   logic                      ready;
   logic                      slice_valid;
   logic signed [SLICE_W-1:0] slice_us;
   logic signed [TS_W-1:0]    total_us;

   modport source (output valid, slice_valid, slice_us, total_us, input ready);
   modport sink   (input valid, slice_valid, slice_us, total_us, output ready);
endinterface

### hdl/rta_ctrl.sv
// Sequencer for the clearing pass and the read-modify-write of each beat.
module rta_ctrl import rta_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_ready,
   input  rta_status_type status,
   output rta_cmd_type    cmd
);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_MUL,
      ST_ACC,
      ST_PUSH
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear = 1'b1;
            if (status.clear_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            cmd.capture = req_valid;
            if (req_valid) state_in = ST_READ;
         end
         ST_READ: begin
            cmd.read = 1'b1;
            state_in = ST_MUL;
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_ACC;
         end
         ST_ACC: begin
            cmd.acc  = 1'b1;
            state_in = ST_PUSH;
         end
         ST_PUSH: begin
            if (status.out_free) begin
               cmd.push = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   assign req_ready = (state_ff == ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_CLEAR;
      else       state_ff <= state_in;
   end

endmodule

### hdl/rta_datapath.sv
// Task tables, divide-by-1000 multiplier, accumulator and output register.
module rta_datapath import rta_pkg::*; #(
   parameter int TASK_ENTRIES = 16384
) (
   input  logic                      clock,
   input  logic                      reset,
   input  rta_cmd_type               cmd,
   output rta_status_type            status,
   input  logic signed [TS_W-1:0]    req_time,
   input  logic        [ID_W-1:0]    req_out_id,
   input  logic        [ID_W-1:0]    req_in_id,
   input  logic                      rsp_ready,
   output logic                      rsp_valid,
   output logic                      rsp_slice_valid,
   output logic signed [SLICE_W-1:0] rsp_slice_us,
   output logic signed [TS_W-1:0]    rsp_total_us
);

   localparam int ADDR_W = $clog2(TASK_ENTRIES);

   // entry = {known, value}
   logic [TS_W:0] stamp_mem [TASK_ENTRIES];
   logic [TS_W:0] sum_mem   [TASK_ENTRIES];

   logic [ADDR_W-1:0] clr_cnt_ff;
   logic [TS_W-1:0]   ts_ff;
   logic [ADDR_W-1:0] out_addr_ff, in_addr_ff;
   logic              out_ok_ff, in_ok_ff;
   logic [TS_W:0]     stamp_rd_ff, sum_rd_ff;
   logic [PROD_W-1:0] prod_ff;
   logic              neg_ff, hit_ff;
   logic              res_valid_ff;
   logic [SLICE_W-1:0] res_slice_ff;
   logic [TS_W-1:0]   res_total_ff;
   logic              out_valid_ff, out_slice_valid_ff;
   logic [SLICE_W-1:0] out_slice_ff;
   logic [TS_W-1:0]   out_total_ff;

   logic [31:0]       out_ext, in_ext;
   logic [TS_W-1:0]   diff, mag;
   logic [SLICE_W-1:0] quot, slice;
   logic [TS_W-1:0]   slice_ext, total;
   logic              stamp_we, sum_we;
   logic [ADDR_W-1:0] stamp_wa, sum_wa;
   logic [TS_W:0]     stamp_wd, sum_wd;

   assign out_ext = 32'(req_out_id);
   assign in_ext  = 32'(req_in_id);

   assign diff      = ts_ff - stamp_rd_ff[TS_W-1:0];
   assign mag       = diff[TS_W-1] ? (TS_W'(0) - diff) : diff;
   assign quot      = prod_ff[DIV_SHIFT +: SLICE_W];
   assign slice     = neg_ff ? (SLICE_W'(0) - quot) : quot;
   assign slice_ext = {{(TS_W-SLICE_W){slice[SLICE_W-1]}}, slice};
   assign total     = sum_rd_ff[TS_W] ? (sum_rd_ff[TS_W-1:0] + slice_ext) : slice_ext;

   assign stamp_we = cmd.clear || (cmd.acc && in_ok_ff);
   assign stamp_wa = cmd.clear ? clr_cnt_ff : in_addr_ff;
   assign stamp_wd = cmd.clear ? '0 : {1'b1, ts_ff};
   assign sum_we   = cmd.clear || (cmd.acc && hit_ff);
   assign sum_wa   = cmd.clear ? clr_cnt_ff : out_addr_ff;
   assign sum_wd   = cmd.clear ? '0 : {1'b1, total};

   assign status.clear_last = (clr_cnt_ff == ADDR_W'(TASK_ENTRIES - 1));
   assign status.out_free   = !out_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (stamp_we) stamp_mem[stamp_wa] <= stamp_wd;
      if (cmd.read) stamp_rd_ff <= stamp_mem[out_addr_ff];
   end

   always_ff @(posedge clock) begin
      if (sum_we) sum_mem[sum_wa] <= sum_wd;
      if (cmd.read) sum_rd_ff <= sum_mem[out_addr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset)          clr_cnt_ff <= '0;
      else if (cmd.clear) clr_cnt_ff <= clr_cnt_ff + ADDR_W'(1);
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         ts_ff       <= req_time;
         out_addr_ff <= out_ext[ADDR_W-1:0];
         in_addr_ff  <= in_ext[ADDR_W-1:0];
         out_ok_ff   <= out_ext < 32'(TASK_ENTRIES);
         in_ok_ff    <= in_ext < 32'(TASK_ENTRIES);
      end
      if (cmd.mul) begin
         prod_ff <= PROD_W'(mag) * PROD_W'(DIV_MAGIC);
         neg_ff  <= diff[TS_W-1];
         hit_ff  <= out_ok_ff && stamp_rd_ff[TS_W];
      end
      if (cmd.acc) begin
         res_valid_ff <= hit_ff;
         res_slice_ff <= hit_ff ? slice : '0;
         res_total_ff <= hit_ff ? total : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset)          out_valid_ff <= 1'b0;
      else if (cmd.push)  out_valid_ff <= 1'b1;
      else if (rsp_ready) out_valid_ff <= 1'b0;
   end

   always_ff @(posedge clock) begin
      if (cmd.push) begin
         out_slice_valid_ff <= res_valid_ff;
         out_slice_ff       <= res_slice_ff;
         out_total_ff       <= res_total_ff;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_slice_valid = out_slice_valid_ff;
   assign rsp_slice_us    = out_slice_ff;
   assign rsp_total_us    = out_total_ff;

endmodule

### hdl/per_task_runtime_accounting_core.sv
// Top level of the per-task runtime accounting block.
// Usage:
//   req_ch carries one task switch per beat: timestamp in ns, outgoing id,
//   incoming id. rsp_ch returns exactly one beat per switch, in order:
//   slice_valid, the slice in us (truncated toward zero) and the outgoing
//   task's running total. Both channels use valid/ready.
//   Each switch is a read-modify-write of two task tables held in single
//   memories: accept, table read, divide-by-1000 multiply, accumulate and
//   write back, load the output register. req_ch.ready rises again in
//   the same cycle as the result is shown; the sequence is set by the
//   registered table read and the multiplier stage, and the load waits
//   while the output register still holds an unaccepted beat.
//   After reset a clearing pass marks every table entry empty, one entry a
//   cycle; req_ch.ready stays low until it ends.
//   A stalled rsp_ch holds its beat in the output register; one more switch
//   is processed and then waits until the register frees.
//   Ids at or beyond TASK_ENTRIES are treated as having no entry.
module per_task_runtime_accounting_core import rta_pkg::*; #(
   parameter int TASK_ENTRIES = 16384
) (
   input  logic     clock,
   input  logic     reset,
   rta_req_if.sink   req_ch,
   rta_rsp_if.source rsp_ch
);

   rta_cmd_type    cmd;
   rta_status_type status;

   rta_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   rta_datapath #(
      .TASK_ENTRIES (TASK_ENTRIES)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_time        (req_ch.switch_time_ns),
      .req_out_id      (req_ch.outgoing_task),
      .req_in_id       (req_ch.incoming_task),
      .rsp_ready       (rsp_ch.ready),
      .rsp_valid       (rsp_ch.valid),
      .rsp_slice_valid (rsp_ch.slice_valid),
      .rsp_slice_us    (rsp_ch.slice_us),
      .rsp_total_us    (rsp_ch.total_us)
   );

   // reset starts the clearing pass
   a_clear_after_reset: assert property (@(posedge clock)
      reset |=> !req_ch.ready)
      else $error("ready high right after reset");

   // one switch at a time
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_ch.valid && req_ch.ready |=> !req_ch.ready)
      else $error("new beat taken while one is in flight");

   // a task with no start returns zero fields
   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && !rsp_ch.slice_valid |-> rsp_ch.slice_us == '0 && rsp_ch.total_us == '0)
      else $error("nonzero fields without a slice");

endmodule

### bench/rta_accounting_checker.sv
// Watches the switch and result channels, predicts every result beat and compares it.
module rta_accounting_checker import rta_pkg::*; #(
   parameter int TASK_ENTRIES = 16384
) (
   input  logic clock,
   input  logic reset,
   rta_req_if   req_mon,
   rta_rsp_if   rsp_mon,
   output int   mismatches,
   output int   awaiting
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NS_PER_US  = 1000;
   localparam int MAX_REPORT = 10;

   typedef struct packed {
      logic               slice_valid;
      logic [SLICE_W-1:0] slice_us;
      logic [TS_W-1:0]    total_us;
   } slice_report_type;

   logic [TS_W-1:0] start_ns   [TASK_ENTRIES];
   bit              start_set  [TASK_ENTRIES];
   logic [TS_W-1:0] runtime_us [TASK_ENTRIES];
   bit              runtime_set[TASK_ENTRIES];

   slice_report_type owed_slices[$];
   int               fails = 0;
   int               owed_count = 0;

   assign mismatches = fails;
   assign awaiting   = owed_count;

   // two's complement ns difference to us, truncated toward zero
   function automatic logic [TS_W-1:0] ns_to_us(logic [TS_W-1:0] diff);
      logic [TS_W-1:0] mag;
      logic [TS_W-1:0] quo;
      mag = diff[TS_W-1] ? -diff : diff;
      quo = mag / NS_PER_US;
      return diff[TS_W-1] ? -quo : quo;
   endfunction

   function automatic slice_report_type account_switch(logic [TS_W-1:0] ts,
                                                       logic [ID_W-1:0] out_id,
                                                       logic [ID_W-1:0] in_id);
      slice_report_type rep;
      logic [TS_W-1:0]  slice;
      logic [TS_W-1:0]  total;
      rep = '0;
      if (out_id < TASK_ENTRIES && start_set[out_id]) begin
         slice = ns_to_us(ts - start_ns[out_id]);
         total = runtime_set[out_id] ? runtime_us[out_id] + slice : slice;
         runtime_us[out_id]  = total;
         runtime_set[out_id] = 1'b1;
         rep.slice_valid = 1'b1;
         rep.slice_us    = slice[SLICE_W-1:0];
         rep.total_us    = total;
      end
      // the incoming start is written after the outgoing update, so out == in works
      if (in_id < TASK_ENTRIES) begin
         start_ns[in_id]  = ts;
         start_set[in_id] = 1'b1;
      end
      return rep;
   endfunction

   task automatic flag(string what, slice_report_type want, slice_report_type got);
      if (fails < MAX_REPORT) begin
         $display("%0t ns: %s", $time, what);
         $display("   expected valid=%0b slice_us=%0d total_us=%0d",
                  want.slice_valid, $signed(want.slice_us), $signed(want.total_us));
         $display("   actual   valid=%0b slice_us=%0d total_us=%0d",
                  got.slice_valid, $signed(got.slice_us), $signed(got.total_us));
      end
      fails++;
   endtask

   always @(posedge clock) begin
      slice_report_type got;
      slice_report_type want;
      if (reset) begin
         foreach (start_set[i]) begin
            start_set[i]   = 1'b0;
            runtime_set[i] = 1'b0;
         end
         owed_slices.delete();
      end else begin
         // result first: a beat leaving at this edge can't belong to one entering now
         if (rsp_mon.valid && rsp_mon.ready) begin
            got.slice_valid = rsp_mon.slice_valid;
            got.slice_us    = rsp_mon.slice_us;
            got.total_us    = rsp_mon.total_us;
            if (owed_slices.size() == 0) begin
               flag("result beat with no switch outstanding", '0, got);
            end else begin
               want = owed_slices.pop_front();
               if (got.slice_valid !== want.slice_valid || got.slice_us !== want.slice_us ||
                   got.total_us !== want.total_us)
                  flag("result beat differs", want, got);
            end
         end
         if (req_mon.valid && req_mon.ready)
            owed_slices.push_back(account_switch(req_mon.switch_time_ns,
                                                 req_mon.outgoing_task,
                                                 req_mon.incoming_task));
      end
      owed_count = owed_slices.size();
   end

endmodule

### bench/per_task_runtime_accounting_core_test.sv
// Test top: drives task switches, paces the result channel and reports the verdict.
module per_task_runtime_accounting_core_test import rta_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int TASK_ENTRIES    = 16384;
   localparam int RANDOM_SWITCHES = 1500;
   localparam int PHASES          = 4;
   localparam int POOL_SIZE       = 16;
   localparam int POOL_W          = $clog2(POOL_SIZE);
   localparam int HOLD_CYCLES     = 400;
   localparam int SETTLE_CYCLES   = 20;
   localparam logic [ID_W-1:0] TOP_ID = '1;

   logic clock;
   logic reset;
   logic hold_on;
   int   send_idle_pct;
   int   stall_pct;
   int   mismatches;
   int   awaiting;
   int   switches_sent = 0;

   logic [ID_W-1:0] task_pool[POOL_SIZE];
   logic [ID_W-1:0] running_task;
   logic [TS_W-1:0] now_ns;

   rta_req_if req_ch();
   rta_rsp_if rsp_ch();

   per_task_runtime_accounting_core #(.TASK_ENTRIES(TASK_ENTRIES)) dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   rta_accounting_checker #(.TASK_ENTRIES(TASK_ENTRIES)) checker_i (
      .clock      (clock),
      .reset      (reset),
      .req_mon    (req_ch),
      .rsp_mon    (rsp_ch),
      .mismatches (mismatches),
      .awaiting   (awaiting)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   always @(posedge clock) begin
      if (hold_on)
         rsp_ch.ready <= 1'b0;
      else
         rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
   end

   task automatic hold_receiver(int cycles);
      hold_on <= 1'b1;
      repeat (cycles) @(posedge clock);
      hold_on <= 1'b0;
   endtask

   task automatic send_switch(logic [TS_W-1:0] ts, logic [ID_W-1:0] out_id,
                              logic [ID_W-1:0] in_id);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid          <= 1'b1;
      req_ch.switch_time_ns <= ts;
      req_ch.outgoing_task  <= out_id;
      req_ch.incoming_task  <= in_id;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      switches_sent++;
   endtask

   // sender stays quiet until every owed result beat has come back
   task automatic wait_drain();
      req_ch.valid <= 1'b0;
      @(negedge clock);
      while (awaiting != 0) @(negedge clock);
      @(posedge clock);
   endtask

   function automatic logic [TS_W-1:0] random_step();
      int pick;
      pick = $urandom_range(99);
      if (pick < 50)      return $urandom_range(20000);
      else if (pick < 80) return $urandom_range(5_000_000);
      else if (pick < 95) return $urandom();
      else                return -$urandom_range(3000);
   endfunction

   // mostly a plausible schedule (outgoing == task that came in last), some noise
   task automatic random_switches(int count);
      int              pick;
      logic [TS_W-1:0] ts;
      logic [ID_W-1:0] out_id;
      logic [ID_W-1:0] in_id;
      repeat (count) begin
         pick = $urandom_range(99);
         if (pick < 80) begin
            out_id = running_task;
            in_id  = ($urandom_range(9) == 0) ? running_task
                        : task_pool[POOL_W'($urandom_range(POOL_SIZE-1))];
            ts     = now_ns + random_step();
            now_ns       = ts;
            running_task = in_id;
         end else if (pick < 90) begin
            out_id = task_pool[POOL_W'($urandom_range(POOL_SIZE-1))];
            in_id  = task_pool[POOL_W'($urandom_range(POOL_SIZE-1))];
            ts     = now_ns + random_step();
            now_ns       = ts;
            running_task = in_id;
         end else begin
            out_id = ID_W'($urandom_range(TOP_ID));
            in_id  = ID_W'($urandom_range(TOP_ID));
            ts     = $urandom();
         end
         send_switch(ts, out_id, in_id);
      end
   endtask

   initial begin
      int directed_count;
      reset                 = 1'b1;
      hold_on               = 1'b0;
      send_idle_pct         = 0;
      stall_pct             = 0;
      req_ch.valid          = 1'b0;
      req_ch.switch_time_ns = '0;
      req_ch.outgoing_task  = '0;
      req_ch.incoming_task  = '0;
      rsp_ch.ready          = 1'b0;
      foreach (task_pool[i]) task_pool[i] = ID_W'($urandom_range(TOP_ID));
      running_task = task_pool[0];
      now_ns       = $urandom();

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      send_switch(32'h0000_0000, 14'd0, 14'd0);       // no start recorded yet
      send_switch(32'h7FFF_FFFF, 14'd0, 14'd1);       // largest positive slice, new total
      send_switch(32'h0000_0000, TOP_ID, 14'd3);      // highest id, no start
      send_switch(32'h8000_0000, 14'd3, 14'd3);       // most negative difference
      send_switch(32'h8000_03E7, 14'd3, 14'd3);       // 999 ns truncates to zero
      send_switch(32'h8000_07CF, 14'd3, 14'd3);       // exactly one us
      send_switch(32'h8000_0000, 14'd3, TOP_ID);      // negative slice toward zero
      send_switch(32'h7FFF_FFFF, TOP_ID, TOP_ID);     // difference wraps to -1
      send_switch(32'h7FFF_FFFF, 14'd1, 14'd0);       // zero slice on a new total
      send_switch(32'h0000_03E8, 14'd0, 14'h2AAA);    // adds onto an existing total
      send_switch(32'hFFFF_FC18, 14'h2AAA, 14'h1555);
      send_switch(32'hFFFF_FFFF, 14'h1555, 14'h3FFF);
      send_switch(32'h1234_5678, 14'h3FFF, 14'd0);
      directed_count = switches_sent;
      wait_drain();

      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0: begin
               send_idle_pct = 0;
               stall_pct    <= 0;
               // long response hold while switches keep coming: block must back up
               fork
                  hold_receiver(HOLD_CYCLES);
               join_none
            end
            1: begin
               send_idle_pct = 63;
               stall_pct    <= 0;
            end
            2: begin
               send_idle_pct = 0;
               stall_pct    <= 63;
            end
            default: begin
               send_idle_pct = 18;
               stall_pct    <= 18;
            end
         endcase
         random_switches(RANDOM_SWITCHES / PHASES);
         wait_drain();
      end

      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("Ran %0d task switches (%0d directed) over four sender/receiver idle mixes,",
               switches_sent, directed_count);
      $display("with a %0d-cycle response hold and a full drain after each phase.",
               HOLD_CYCLES);
      if (mismatches == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("Timed out with %0d result beats still owed", awaiting);
      $display("== FAIL ==");
      $finish;
   end

endmodule
